// File: src/mtt_pkg.sv
// ----------------------------------------------------------------------------
// mtt_pkg: shared types and constants for the timer table
// Transaction structs, mode and result codes, entry flag values and the
// sequencer state type.
// ----------------------------------------------------------------------------
package mtt_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int IDX_W      = 4;
    localparam int TAG_W      = 8;
    localparam int TICK_W     = 32;

    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_ALLOC = 3'd1;
    localparam logic [2:0] MODE_FREE  = 3'd2;
    localparam logic [2:0] MODE_INIT  = 3'd3;
    localparam logic [2:0] MODE_SET   = 3'd4;

    localparam logic [1:0] KIND_ALLOCATED = 2'd0;
    localparam logic [1:0] KIND_NONE_FREE = 2'd1;
    localparam logic [1:0] KIND_EXPIRED   = 2'd2;

    localparam logic [1:0] FLAGS_FREE  = 2'd0;
    localparam logic [1:0] FLAGS_ALLOC = 2'd1;
    localparam logic [1:0] FLAGS_USING = 2'd2;

    typedef struct packed {
        logic [2:0]        mode;
        logic [IDX_W-1:0]  timer_index;
        logic [TAG_W-1:0]  tag_value;
        logic [TICK_W-1:0] timeout_ticks;
    } mtt_req_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [IDX_W-1:0]  entry_number;
        logic [TAG_W-1:0]  expired_tag;
        logic [TICK_W-1:0] tick_total;
        logic              last;
    } mtt_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK_SCAN,
        ST_TICK_EMIT,
        ST_ALLOC_SCAN
    } mtt_state_t;

endpackage

// File: src/multi_timer_table.sv
// ----------------------------------------------------------------------------
// multi_timer_table: table of one-shot timers driven by a global tick
// Alloc, free, tag init and arm operations on a small entry table; a tick
// decrements every armed entry and reports each expiry with its tag.
//
//   channel  role    signals                     payload
//   req      input   req_valid, req_ready        mtt_req_t
//   rsp      output  rsp_valid, rsp_ready        mtt_rsp_t
//
// free, init and set complete as they are accepted. alloc walks the entries
// from index 0, one a cycle, until it finds a free one or reaches the last.
// a tick walks all NUM_TIMERS entries through the one decrement unit, then
// emits one response per expiry, lowest index first, or returns to idle when
// nothing expires. req_ready is high only between operations. a full output
// register stalls the sequencer wherever it would emit a response.
// reset clears all entries and the tick count at once.
// ----------------------------------------------------------------------------
module multi_timer_table (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  mtt_pkg::mtt_req_t  req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output mtt_pkg::mtt_rsp_t  rsp
);

    localparam int N = mtt_pkg::NUM_TIMERS;
    localparam int W = mtt_pkg::IDX_W;
    localparam logic [W-1:0] LAST_IDX = W'(N - 1);

    mtt_pkg::mtt_state_t state_reg, state_next;

    logic [1:0]                   flags_reg   [N];
    logic [mtt_pkg::TICK_W-1:0]   timeout_reg [N];
    logic [mtt_pkg::TAG_W-1:0]    tag_reg     [N];
    logic [mtt_pkg::TICK_W-1:0]   tick_reg,     tick_next;
    logic [W-1:0]                 scan_idx_reg, scan_idx_next;
    logic [N-1:0]                 exp_mask_reg, exp_mask_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    mtt_pkg::mtt_rsp_t            rsp_reg,       rsp_next;

    logic                         accept;
    logic                         out_free;
    logic [1:0]                   cur_flags;
    logic [mtt_pkg::TICK_W-1:0]   cur_timeout;
    logic                         alloc_found;
    logic [W-1:0]                 first_idx;
    logic [N-1:0]                 first_onehot;
    logic                         emit;

    logic                         flags_we;
    logic [W-1:0]                 flags_widx;
    logic [1:0]                   flags_wdata;
    logic                         timeout_we;
    logic [W-1:0]                 timeout_widx;
    logic [mtt_pkg::TICK_W-1:0]   timeout_wdata;
    logic                         tag_we;

    assign req_ready   = (state_reg == mtt_pkg::ST_IDLE);
    assign accept      = req_valid && req_ready;
    assign out_free    = !rsp_valid_reg || rsp_ready;
    assign cur_flags   = flags_reg[scan_idx_reg];
    assign cur_timeout = timeout_reg[scan_idx_reg];
    assign alloc_found = (cur_flags == mtt_pkg::FLAGS_FREE);
    assign rsp_valid   = rsp_valid_reg;
    assign rsp         = rsp_reg;

    // lowest pending expiry
    always_comb
    begin
        first_idx = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (exp_mask_reg[i])
            begin
                first_idx = W'(i);
            end
        end
        first_onehot = N'(1) << first_idx;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mtt_pkg::ST_IDLE:
            begin
                if (accept && req.mode == mtt_pkg::MODE_TICK)
                begin
                    state_next = mtt_pkg::ST_TICK_SCAN;
                end
                else if (accept && req.mode == mtt_pkg::MODE_ALLOC)
                begin
                    state_next = mtt_pkg::ST_ALLOC_SCAN;
                end
            end
            mtt_pkg::ST_TICK_SCAN:
            begin
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = mtt_pkg::ST_TICK_EMIT;
                end
            end
            mtt_pkg::ST_TICK_EMIT:
            begin
                if (exp_mask_reg == '0 ||
                    (out_free && (exp_mask_reg & ~first_onehot) == '0))
                begin
                    state_next = mtt_pkg::ST_IDLE;
                end
            end
            mtt_pkg::ST_ALLOC_SCAN:
            begin
                if ((alloc_found || scan_idx_reg == LAST_IDX) && out_free)
                begin
                    state_next = mtt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mtt_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        tick_next     = tick_reg;
        scan_idx_next = scan_idx_reg;
        exp_mask_next = exp_mask_reg;
        emit          = 1'b0;
        rsp_next      = rsp_reg;
        flags_we      = 1'b0;
        flags_widx    = req.timer_index;
        flags_wdata   = mtt_pkg::FLAGS_FREE;
        timeout_we    = 1'b0;
        timeout_widx  = req.timer_index;
        timeout_wdata = req.timeout_ticks;
        tag_we        = 1'b0;

        unique case (state_reg)
            mtt_pkg::ST_IDLE:
            begin
                scan_idx_next = '0;
                if (accept)
                begin
                    priority case (req.mode)
                        mtt_pkg::MODE_TICK:
                        begin
                            tick_next     = tick_reg + 1'b1;
                            exp_mask_next = '0;
                        end
                        mtt_pkg::MODE_FREE:
                        begin
                            flags_we    = 1'b1;
                            flags_wdata = mtt_pkg::FLAGS_FREE;
                        end
                        mtt_pkg::MODE_INIT:
                        begin
                            tag_we = 1'b1;
                        end
                        mtt_pkg::MODE_SET:
                        begin
                            timeout_we  = 1'b1;
                            flags_we    = 1'b1;
                            flags_wdata = mtt_pkg::FLAGS_USING;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            mtt_pkg::ST_TICK_SCAN:
            begin
                scan_idx_next = scan_idx_reg + 1'b1;
                timeout_widx  = scan_idx_reg;
                timeout_wdata = cur_timeout - 1'b1;
                flags_widx    = scan_idx_reg;
                flags_wdata   = mtt_pkg::FLAGS_ALLOC;
                if (cur_flags == mtt_pkg::FLAGS_USING)
                begin
                    timeout_we = 1'b1;
                    if (cur_timeout == mtt_pkg::TICK_W'(1))
                    begin
                        flags_we      = 1'b1;
                        exp_mask_next = exp_mask_reg | (N'(1) << scan_idx_reg);
                    end
                end
            end
            mtt_pkg::ST_TICK_EMIT:
            begin
                if (exp_mask_reg != '0 && out_free)
                begin
                    emit                  = 1'b1;
                    exp_mask_next         = exp_mask_reg & ~first_onehot;
                    rsp_next.kind         = mtt_pkg::KIND_EXPIRED;
                    rsp_next.entry_number = first_idx;
                    rsp_next.expired_tag  = tag_reg[first_idx];
                    rsp_next.tick_total   = tick_reg;
                    rsp_next.last         = ((exp_mask_reg & ~first_onehot) == '0);
                end
            end
            mtt_pkg::ST_ALLOC_SCAN:
            begin
                flags_widx  = scan_idx_reg;
                flags_wdata = mtt_pkg::FLAGS_ALLOC;
                if ((alloc_found || scan_idx_reg == LAST_IDX) && out_free)
                begin
                    emit                  = 1'b1;
                    flags_we              = alloc_found;
                    rsp_next.kind         = alloc_found ? mtt_pkg::KIND_ALLOCATED
                                                        : mtt_pkg::KIND_NONE_FREE;
                    rsp_next.entry_number = alloc_found ? scan_idx_reg : '0;
                    rsp_next.expired_tag  = '0;
                    rsp_next.tick_total   = tick_reg;
                    rsp_next.last         = 1'b1;
                end
                else if (!alloc_found && scan_idx_reg != LAST_IDX)
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        rsp_valid_next = emit ? 1'b1 : (rsp_valid_reg && !rsp_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mtt_pkg::ST_IDLE;
            tick_reg      <= '0;
            scan_idx_reg  <= '0;
            exp_mask_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            scan_idx_reg  <= scan_idx_next;
            exp_mask_reg  <= exp_mask_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // entry table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                flags_reg[i]   <= mtt_pkg::FLAGS_FREE;
                timeout_reg[i] <= '0;
                tag_reg[i]     <= '0;
            end
        end
        else
        begin
            if (flags_we)
            begin
                flags_reg[flags_widx] <= flags_wdata;
            end
            if (timeout_we)
            begin
                timeout_reg[timeout_widx] <= timeout_wdata;
            end
            if (tag_we)
            begin
                tag_reg[req.timer_index] <= req.tag_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

endmodule

// File: src/mtt_checker.sv
// ----------------------------------------------------------------------------
// mtt_checker: port-level checks for the timer table
// Watches the request and response channels and flags sequencing slips.
// ----------------------------------------------------------------------------
module mtt_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input mtt_pkg::mtt_req_t req,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input mtt_pkg::mtt_rsp_t rsp
);

    // a stalled response transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // alloc always walks the entries instead of completing on acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req.mode == mtt_pkg::MODE_ALLOC |=> !req_ready)
        else $error("alloc finished without a walk");

    // free, init and set complete on acceptance, leaving req_ready high
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready &&
        (req.mode == mtt_pkg::MODE_FREE || req.mode == mtt_pkg::MODE_INIT ||
         req.mode == mtt_pkg::MODE_SET) |=> req_ready)
        else $error("single-cycle operation held the request channel");

    // alloc results are single transactions
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.kind != mtt_pkg::KIND_EXPIRED |-> rsp.last)
        else $error("alloc result without last");

    // no-free result carries zero index and tag
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.kind == mtt_pkg::KIND_NONE_FREE |->
        rsp.entry_number == '0 && rsp.expired_tag == '0)
        else $error("no-free result with non-zero fields");

endmodule

bind multi_timer_table mtt_checker u_mtt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
